// ----- rtl/cial_pkg.sv -----
// ----------------------------------------------------------------------------
// cial_pkg: shared types and constants of the complex integer ALU
// Operation codes, result width and the control word that travels with an
// item down the pipeline.
// ----------------------------------------------------------------------------
package cial_pkg;

   localparam int OPERAND_WIDTH_DEF = 16;
   localparam int RES_WIDTH         = 34;
   localparam int OP_WIDTH          = 2;

   localparam logic [OP_WIDTH-1:0] OP_ADD = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_SUB = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_MUL = 2'd2;
   localparam logic [OP_WIDTH-1:0] OP_DIV = 2'd3;

   typedef struct packed {
      logic                valid;
      logic [OP_WIDTH-1:0] op;
      logic                div_zero;
      logic                neg_re;
      logic                neg_im;
   } ctl_type;

endpackage

// ----- rtl/cial_if.sv -----
// ----------------------------------------------------------------------------
// cial_req_if / cial_rsp_if: valid/ready channels of the complex integer ALU
// One transfer moves one item when valid and ready are both high.
// ----------------------------------------------------------------------------
interface cial_req_if #(
   parameter int OPERAND_WIDTH = 16
);
   logic                            valid;
   logic                            ready;
   logic [1:0]                      operation;
   logic signed [OPERAND_WIDTH-1:0] a_real;
   logic signed [OPERAND_WIDTH-1:0] a_imag;
   logic signed [OPERAND_WIDTH-1:0] b_real;
   logic signed [OPERAND_WIDTH-1:0] b_imag;

   modport source (output valid, operation, a_real, a_imag, b_real, b_imag,
                   input ready);
   modport sink   (input valid, operation, a_real, a_imag, b_real, b_imag,
                   output ready);
endinterface

interface cial_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [33:0] res_real;
   logic signed [33:0] res_imag;
   logic               divide_by_zero;

   modport source (output valid, res_real, res_imag, divide_by_zero, input ready);
   modport sink   (input valid, res_real, res_imag, divide_by_zero, output ready);
endinterface

// ----- rtl/complex_integer_alu.sv -----
// ----------------------------------------------------------------------------
// complex_integer_alu: pipelined add/subtract/multiply/divide of complex ints
//
//   channel   dir   handshake          payload
//   req_chan  in    valid / ready      operation, a_real, a_imag, b_real, b_imag
//   rsp_chan  out   valid / ready      res_real, res_imag, divide_by_zero
//
// One item per cycle while the output is not stalled; the stages are the input register,
// product stage, sum stage, one divider stage per quotient bit and output register.
// All operations go through the same stages, so results leave in order.
// Reset is synchronous and clears every stage valid bit.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module complex_integer_alu #(
   parameter int OPERAND_WIDTH = cial_pkg::OPERAND_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   cial_req_if.sink   req_chan,
   cial_rsp_if.source rsp_chan
);
   import cial_pkg::*;

   localparam int NW = 2 * OPERAND_WIDTH;
   localparam int QX = (NW + 1 > RES_WIDTH) ? NW + 1 : RES_WIDTH;

   logic                              en;
   logic                              in_valid_ff;
   logic [OP_WIDTH-1:0]               in_op_ff;
   logic signed [OPERAND_WIDTH-1:0]   in_a_ff, in_b_ff, in_c_ff, in_d_ff;

   ctl_type              f_ctl, d_ctl;
   logic [RES_WIDTH-1:0] f_fre, f_fim, d_fre, d_fim;
   logic [NW-1:0]        f_nre, f_nim, f_den, q_re, q_im;

   logic                 rsp_valid_ff;
   logic [RES_WIDTH-1:0] res_re_ff, res_im_ff, res_re_in, res_im_in;
   logic                 dz_ff, dz_in;
   logic signed [QX-1:0] qs_re, qs_im;

   // Advance when the output register is free or being drained
   assign en             = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_op_ff <= req_chan.operation;
         in_a_ff  <= req_chan.a_real;
         in_b_ff  <= req_chan.a_imag;
         in_c_ff  <= req_chan.b_real;
         in_d_ff  <= req_chan.b_imag;
      end
   end

   cial_front #(.W(OPERAND_WIDTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (in_valid_ff),
      .in_op    (in_op_ff),
      .in_a     (in_a_ff),
      .in_b     (in_b_ff),
      .in_c     (in_c_ff),
      .in_d     (in_d_ff),
      .ctl_out  (f_ctl),
      .fast_re  (f_fre),
      .fast_im  (f_fim),
      .num_re   (f_nre),
      .num_im   (f_nim),
      .den      (f_den)
   );

   cial_div #(.NW(NW)) u_div (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .ctl_in      (f_ctl),
      .fast_re_in  (f_fre),
      .fast_im_in  (f_fim),
      .num_re_in   (f_nre),
      .num_im_in   (f_nim),
      .den_in      (f_den),
      .ctl_out     (d_ctl),
      .fast_re_out (d_fre),
      .fast_im_out (d_fim),
      .quo_re      (q_re),
      .quo_im      (q_im)
   );

   // Sign the quotients and pick the result
   always_comb begin
      qs_re = QX'($signed({1'b0, q_re}));
      qs_im = QX'($signed({1'b0, q_im}));
      if (d_ctl.neg_re) begin
         qs_re = -qs_re;
      end
      if (d_ctl.neg_im) begin
         qs_im = -qs_im;
      end
      dz_in = 1'b0;
      if (d_ctl.op == OP_DIV) begin
         if (d_ctl.div_zero) begin
            res_re_in = '0;
            res_im_in = '0;
            dz_in     = 1'b1;
         end else begin
            res_re_in = qs_re[RES_WIDTH-1:0];
            res_im_in = qs_im[RES_WIDTH-1:0];
         end
      end else begin
         res_re_in = d_fre;
         res_im_in = d_fim;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= d_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         dz_ff     <= dz_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.res_real       = res_re_ff;
   assign rsp_chan.res_imag       = res_im_ff;
   assign rsp_chan.divide_by_zero = dz_ff;

   // A zero divisor always returns zero parts
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && dz_ff |-> (res_re_ff == '0) && (res_im_ff == '0))
      else $error("divide-by-zero result has nonzero parts");

   // A held pipeline keeps its input stage
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(en) && !$past(reset) |-> $stable(in_valid_ff) && $stable(in_a_ff))
      else $error("input stage moved during stall");

   // A refused result stays on the channel unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff && $stable(res_re_ff) &&
         $stable(res_im_ff) && $stable(dz_ff))
      else $error("result changed while waiting for transfer");

endmodule

// ----- rtl/cial_front.sv -----
// ----------------------------------------------------------------------------
// cial_front: product and sum stages
// Stage A forms the six operand products, stage B the sums, the add, subtract
// and multiply results, and the sign/magnitude dividends and divisor.
// ----------------------------------------------------------------------------
module cial_front #(
   parameter int W = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [cial_pkg::OP_WIDTH-1:0]     in_op,
   input  logic signed [W-1:0]               in_a,
   input  logic signed [W-1:0]               in_b,
   input  logic signed [W-1:0]               in_c,
   input  logic signed [W-1:0]               in_d,
   output cial_pkg::ctl_type                 ctl_out,
   output logic [cial_pkg::RES_WIDTH-1:0]    fast_re,
   output logic [cial_pkg::RES_WIDTH-1:0]    fast_im,
   output logic [2*W-1:0]                    num_re,
   output logic [2*W-1:0]                    num_im,
   output logic [2*W-1:0]                    den
);
   import cial_pkg::*;

   localparam int PW  = 2 * W;
   localparam int EXT = (PW + 1 > RES_WIDTH) ? PW + 1 : RES_WIDTH;

   // Stage A registers
   logic                  a_valid_ff;
   logic [OP_WIDTH-1:0]   a_op_ff;
   logic signed [W-1:0]   a_a_ff, a_b_ff, a_c_ff, a_d_ff;
   logic signed [PW-1:0]  ac_ff, bd_ff, ad_ff, bc_ff, cc_ff, dd_ff;

   // Stage B registers
   ctl_type               b_ctl_ff;
   logic [RES_WIDTH-1:0]  b_fre_ff, b_fim_ff;
   logic [PW-1:0]         b_nre_ff, b_nim_ff, b_den_ff;

   // Stage B logic
   logic signed [W:0]     sum_re, sum_im, dif_re, dif_im;
   logic signed [PW:0]    mul_re, mul_im, dvn_re, dvn_im;
   logic [PW:0]           den_full;
   logic signed [EXT-1:0] ext_re, ext_im;
   ctl_type               b_ctl_in;
   logic [PW:0]           mag_re, mag_im;

   // Multiply operands
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_op_ff <= in_op;
         a_a_ff  <= in_a;
         a_b_ff  <= in_b;
         a_c_ff  <= in_c;
         a_d_ff  <= in_d;
         ac_ff   <= PW'(in_a) * PW'(in_c);
         bd_ff   <= PW'(in_b) * PW'(in_d);
         ad_ff   <= PW'(in_a) * PW'(in_d);
         bc_ff   <= PW'(in_b) * PW'(in_c);
         cc_ff   <= PW'(in_c) * PW'(in_c);
         dd_ff   <= PW'(in_d) * PW'(in_d);
      end
   end

   // Form sums and select the non-divide result
   always_comb begin
      sum_re   = (W+1)'(a_a_ff) + (W+1)'(a_c_ff);
      sum_im   = (W+1)'(a_b_ff) + (W+1)'(a_d_ff);
      dif_re   = (W+1)'(a_a_ff) - (W+1)'(a_c_ff);
      dif_im   = (W+1)'(a_b_ff) - (W+1)'(a_d_ff);
      mul_re   = (PW+1)'(ac_ff) - (PW+1)'(bd_ff);
      mul_im   = (PW+1)'(ad_ff) + (PW+1)'(bc_ff);
      dvn_re   = (PW+1)'(ac_ff) + (PW+1)'(bd_ff);
      dvn_im   = (PW+1)'(bc_ff) - (PW+1)'(ad_ff);
      den_full = (PW+1)'($unsigned(cc_ff)) + (PW+1)'($unsigned(dd_ff));
      mag_re   = dvn_re[PW] ? $unsigned(-dvn_re) : $unsigned(dvn_re);
      mag_im   = dvn_im[PW] ? $unsigned(-dvn_im) : $unsigned(dvn_im);

      case (a_op_ff)
         OP_ADD: begin
            ext_re = EXT'(sum_re);
            ext_im = EXT'(sum_im);
         end
         OP_SUB: begin
            ext_re = EXT'(dif_re);
            ext_im = EXT'(dif_im);
         end
         default: begin
            ext_re = EXT'(mul_re);
            ext_im = EXT'(mul_im);
         end
      endcase

      b_ctl_in.valid    = a_valid_ff;
      b_ctl_in.op       = a_op_ff;
      b_ctl_in.div_zero = (a_op_ff == OP_DIV) && (den_full == '0);
      b_ctl_in.neg_re   = dvn_re[PW];
      b_ctl_in.neg_im   = dvn_im[PW];
   end

   // Register sums
   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctl_ff <= '0;
      end else if (en) begin
         b_ctl_ff <= b_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_fre_ff <= ext_re[RES_WIDTH-1:0];
         b_fim_ff <= ext_im[RES_WIDTH-1:0];
         b_nre_ff <= mag_re[PW-1:0];
         b_nim_ff <= mag_im[PW-1:0];
         b_den_ff <= den_full[PW-1:0];
      end
   end

   assign ctl_out = b_ctl_ff;
   assign fast_re = b_fre_ff;
   assign fast_im = b_fim_ff;
   assign num_re  = b_nre_ff;
   assign num_im  = b_nim_ff;
   assign den     = b_den_ff;

endmodule

// ----- rtl/cial_div.sv -----
// ----------------------------------------------------------------------------
// cial_div: pipelined restoring divider pair
// One quotient bit per stage for both dividends, with the control word and
// the non-divide result carried alongside.
// ----------------------------------------------------------------------------
module cial_div #(
   parameter int NW = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  cial_pkg::ctl_type                 ctl_in,
   input  logic [cial_pkg::RES_WIDTH-1:0]    fast_re_in,
   input  logic [cial_pkg::RES_WIDTH-1:0]    fast_im_in,
   input  logic [NW-1:0]                     num_re_in,
   input  logic [NW-1:0]                     num_im_in,
   input  logic [NW-1:0]                     den_in,
   output cial_pkg::ctl_type                 ctl_out,
   output logic [cial_pkg::RES_WIDTH-1:0]    fast_re_out,
   output logic [cial_pkg::RES_WIDTH-1:0]    fast_im_out,
   output logic [NW-1:0]                     quo_re,
   output logic [NW-1:0]                     quo_im
);
   import cial_pkg::*;

   ctl_type              ctl_ff  [NW];
   logic [RES_WIDTH-1:0] fre_ff  [NW];
   logic [RES_WIDTH-1:0] fim_ff  [NW];
   logic [NW-1:0]        rre_ff  [NW];
   logic [NW-1:0]        rim_ff  [NW];
   logic [NW-1:0]        nre_ff  [NW];
   logic [NW-1:0]        nim_ff  [NW];
   logic [NW-1:0]        den_ff  [NW];

   genvar k;
   generate
      for (k = 0; k < NW; k++) begin : g_stage
         ctl_type              p_ctl;
         logic [RES_WIDTH-1:0] p_fre, p_fim;
         logic [NW-1:0]        p_rre, p_rim, p_nre, p_nim, p_den;
         logic [NW:0]          t_re, t_im, d_ext, s_re, s_im;
         logic                 ge_re, ge_im;

         if (k == 0) begin : g_first
            assign p_ctl = ctl_in;
            assign p_fre = fast_re_in;
            assign p_fim = fast_im_in;
            assign p_rre = '0;
            assign p_rim = '0;
            assign p_nre = num_re_in;
            assign p_nim = num_im_in;
            assign p_den = den_in;
         end else begin : g_next
            assign p_ctl = ctl_ff[k-1];
            assign p_fre = fre_ff[k-1];
            assign p_fim = fim_ff[k-1];
            assign p_rre = rre_ff[k-1];
            assign p_rim = rim_ff[k-1];
            assign p_nre = nre_ff[k-1];
            assign p_nim = nim_ff[k-1];
            assign p_den = den_ff[k-1];
         end

         // Shift in the next dividend bit, trial subtract
         always_comb begin
            d_ext = {1'b0, p_den};
            t_re  = {p_rre, p_nre[NW-1]};
            t_im  = {p_rim, p_nim[NW-1]};
            ge_re = (t_re >= d_ext);
            ge_im = (t_im >= d_ext);
            s_re  = ge_re ? (t_re - d_ext) : t_re;
            s_im  = ge_im ? (t_im - d_ext) : t_im;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               ctl_ff[k] <= '0;
            end else if (en) begin
               ctl_ff[k] <= p_ctl;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               fre_ff[k] <= p_fre;
               fim_ff[k] <= p_fim;
               den_ff[k] <= p_den;
               rre_ff[k] <= s_re[NW-1:0];
               rim_ff[k] <= s_im[NW-1:0];
               nre_ff[k] <= {p_nre[NW-2:0], ge_re};
               nim_ff[k] <= {p_nim[NW-2:0], ge_im};
            end
         end
      end
   endgenerate

   assign ctl_out     = ctl_ff[NW-1];
   assign fast_re_out = fre_ff[NW-1];
   assign fast_im_out = fim_ff[NW-1];
   assign quo_re      = nre_ff[NW-1];
   assign quo_im      = nim_ff[NW-1];

   // Final remainders stay below a nonzero divisor
   a_rem_re: assert property (@(posedge clock) disable iff (reset)
      ctl_ff[NW-1].valid && (den_ff[NW-1] != '0) |-> rre_ff[NW-1] < den_ff[NW-1])
      else $error("real remainder not below divisor");
   a_rem_im: assert property (@(posedge clock) disable iff (reset)
      ctl_ff[NW-1].valid && (den_ff[NW-1] != '0) |-> rim_ff[NW-1] < den_ff[NW-1])
      else $error("imaginary remainder not below divisor");

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the complex integer ALU
// Drives add, subtract, multiply and divide items through the request channel
// and checks every result against an in-bench computation of the expected
// parts and divide-by-zero flag, with random idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb_top;
   import cial_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int W       = OPERAND_WIDTH_DEF;
   localparam int LATENCY = 2 * W + 4;

   typedef struct {
      logic [OP_WIDTH-1:0] op;
      logic signed [W-1:0] ar, ai, br, bi;
   } alu_item_type;

   typedef struct {
      logic [RES_WIDTH-1:0] re, im;
      logic                 dz;
   } alu_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cial_req_if #(.OPERAND_WIDTH(W)) req_chan ();
   cial_rsp_if                      rsp_chan ();

   complex_integer_alu #(.OPERAND_WIDTH(W)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   alu_item_type   pending_items[$];
   alu_result_type expected_results[$];
   int             mismatch_count = 0;
   bit             stimulus_done  = 1'b0;
   bit             drain_request  = 1'b0;
   int             long_hold      = 0;

   // clock and reset
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // compute the expected complex result
   function automatic alu_result_type complex_result(alu_item_type it);
      alu_result_type r;
      longint a, b, c, d, den, nre, nim, qre, qim;
      a = it.ar; b = it.ai; c = it.br; d = it.bi;
      r.dz = 1'b0;
      r.re = '0;
      r.im = '0;
      case (it.op)
         OP_ADD: begin
            r.re = RES_WIDTH'(a + c);
            r.im = RES_WIDTH'(b + d);
         end
         OP_SUB: begin
            r.re = RES_WIDTH'(a - c);
            r.im = RES_WIDTH'(b - d);
         end
         OP_MUL: begin
            r.re = RES_WIDTH'(a * c - b * d);
            r.im = RES_WIDTH'(a * d + b * c);
         end
         default: begin
            den = c * c + d * d;
            if (den == 0) begin
               r.dz = 1'b1;
            end else begin
               // SV signed division truncates toward zero
               nre = a * c + b * d;
               nim = b * c - a * d;
               qre = nre / den;
               qim = nim / den;
               r.re = RES_WIDTH'(qre);
               r.im = RES_WIDTH'(qim);
            end
         end
      endcase
      return r;
   endfunction

   function automatic logic signed [W-1:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return {1'b1, {(W-1){1'b0}}};
         1: return {1'b0, {(W-1){1'b1}}};
         2: return '0;
         3: return W'($signed($urandom_range(0, 6)) - 3);
         4: return W'($signed($urandom_range(0, 510)) - 255);
         default: return W'($urandom);
      endcase
   endfunction

   task automatic push_item(logic [OP_WIDTH-1:0] op, logic signed [W-1:0] ar,
                            logic signed [W-1:0] ai, logic signed [W-1:0] br,
                            logic signed [W-1:0] bi);
      alu_item_type it;
      it.op = op; it.ar = ar; it.ai = ai; it.br = br; it.bi = bi;
      pending_items.push_back(it);
   endtask

   // fill the stimulus queue
   initial begin
      logic signed [W-1:0] mx, mn;
      logic [OP_WIDTH-1:0] ops[4];
      ops[0] = OP_ADD; ops[1] = OP_SUB; ops[2] = OP_MUL; ops[3] = OP_DIV;
      mx = {1'b0, {(W-1){1'b1}}};
      mn = {1'b1, {(W-1){1'b0}}};
      // directed extremes for every operation
      foreach (ops[k]) begin
         push_item(ops[k], mx, mx, mx, mx);
         push_item(ops[k], mn, mn, mn, mn);
         push_item(ops[k], mn, mx, mx, mn);
         push_item(ops[k], W'(7), W'(-7), W'(2), W'(-3));
      end
      // zero divisor and near-zero cases
      push_item(OP_DIV, W'(5), W'(-9), '0, '0);
      push_item(OP_DIV, mn, mn, '0, '0);
      push_item(OP_DIV, '0, '0, '0, '0);
      push_item(OP_DIV, W'(-7), W'(3), W'(1), '0);
      push_item(OP_DIV, '0, '0, mn, mx);
      push_item(OP_ADD, '0, '0, '0, '0);
      // random part, even mix of operations
      for (int n = 0; n < 1530; n++)
         push_item(ops[$urandom_range(0, 3)], pick_operand(), pick_operand(),
                   pick_operand(), pick_operand());
   end

   // request driver
   int send_gap = 0;
   int sent     = 0;
   bit waiting_drain = 1'b0;
   initial begin
      req_chan.valid     = 1'b0;
      req_chan.operation = '0;
      req_chan.a_real    = '0;
      req_chan.a_imag    = '0;
      req_chan.b_real    = '0;
      req_chan.b_imag    = '0;
   end

   always @(posedge clock) begin
      alu_item_type it;
      bit           fire;
      fire = req_chan.valid && req_chan.ready;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (req_chan.valid && !fire) begin
         // hold until transfer
      end else if (waiting_drain) begin
         req_chan.valid <= 1'b0;
         if (expected_results.size() == 0 && !fire) waiting_drain <= 1'b0;
      end else if (send_gap > 0) begin
         req_chan.valid <= 1'b0;
         send_gap <= send_gap - 1;
      end else if (pending_items.size() > 0) begin
         it = pending_items.pop_front();
         req_chan.valid     <= 1'b1;
         req_chan.operation <= it.op;
         req_chan.a_real    <= it.ar;
         req_chan.a_imag    <= it.ai;
         req_chan.b_real    <= it.br;
         req_chan.b_imag    <= it.bi;
         sent <= sent + 1;
         // pause once until all results are back
         if (sent == 900) waiting_drain <= 1'b1;
         send_gap <= ($urandom_range(0, 3) == 0) ? 0 :
                     (sent > 300 && sent < 600) ? 0 : $urandom_range(0, 12);
      end else begin
         req_chan.valid <= 1'b0;
         stimulus_done  <= 1'b1;
      end
   end

   // record expectations on request transfer
   always @(posedge clock) begin
      alu_item_type it;
      if (!reset && req_chan.valid && req_chan.ready) begin
         it.op = req_chan.operation;
         it.ar = req_chan.a_real;
         it.ai = req_chan.a_imag;
         it.br = req_chan.b_real;
         it.bi = req_chan.b_imag;
         expected_results.push_back(complex_result(it));
      end
   end

   // response monitor and ready driver
   int recv_gap = 0;
   int received = 0;
   initial rsp_chan.ready = 1'b0;

   always @(posedge clock) begin
      alu_result_type e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         received <= received + 1;
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result re=%0d im=%0d dz=%0b",
                        rsp_chan.res_real, rsp_chan.res_imag,
                        rsp_chan.divide_by_zero);
         end else begin
            e = expected_results.pop_front();
            if (rsp_chan.res_real !== e.re || rsp_chan.res_imag !== e.im ||
                rsp_chan.divide_by_zero !== e.dz) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected re=%0d im=%0d dz=%0b, got re=%0d im=%0d dz=%0b",
                           $signed(e.re), $signed(e.im), e.dz, rsp_chan.res_real,
                           rsp_chan.res_imag, rsp_chan.divide_by_zero);
            end
         end
      end
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (long_hold > 0) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_chan.ready && !(rsp_chan.valid)) begin
         // keep ready while waiting for data
      end else if (recv_gap > 0) begin
         rsp_chan.ready <= 1'b0;
         recv_gap <= recv_gap - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (rsp_chan.ready && rsp_chan.valid)
            recv_gap <= (received > 300 && received < 600) ? 0 : $urandom_range(0, 12);
      end
   end

   // long receiver hold-off so the pipeline fills and stalls the input
   always @(posedge clock) begin
      if (!reset && sent == 1200 && long_hold == 0 && !drain_request) begin
         long_hold     <= 200;
         drain_request <= 1'b1;
      end else if (long_hold > 0) begin
         long_hold <= long_hold - 1;
      end
   end

   // end of run
   initial begin
      wait (stimulus_done);
      wait (expected_results.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("complex_integer_alu verification clean");
      else
         $display("complex_integer_alu verification failed");
      $finish;
   end

   initial begin
      #2ms;
      $display("complex_integer_alu verification failed");
      $finish;
   end

endmodule
